[sv/iso8583_message_field_splitter_assert.svh]
// Assertion macros for the field splitter
`ifndef ISO8583_MESSAGE_FIELD_SPLITTER_ASSERT_SVH
`define ISO8583_MESSAGE_FIELD_SPLITTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IMFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imfs check failed");

// antecedent implies consequent in the next cycle
`define IMFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imfs check failed");

`endif

[sv/imfs_pkg.sv]
package imfs_pkg;

    localparam int TABLE_DEPTH = 129;
    localparam int TABLE_AW    = 8;
    localparam int BITMAP_BITS = 128;

    // opcodes
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_MSG_BYTE    = 1'b1;

    // entry formats
    localparam logic [1:0] FMT_BINARY    = 2'd2;
    localparam logic [1:0] FMT_UNDEFINED = 2'd3;

    // byte roles
    localparam logic [1:0] ROLE_TYPE    = 2'd0;
    localparam logic [1:0] ROLE_BITMAP  = 2'd1;
    localparam logic [1:0] ROLE_PREFIX  = 2'd2;
    localparam logic [1:0] ROLE_CONTENT = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG = 3'd1;
    localparam logic [2:0] ERR_BAD_FMT = 3'd2;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd3;
    localparam logic [2:0] ERR_EARLY   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_TYPE_LEN   = 2'd0;
    localparam logic [1:0] CFG_BITMAP_HEX = 2'd1;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_BITMAP,
        PH_PREFIX,
        PH_CONTENT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [2:0]  digits;
        logic [13:0] max_len;
    } t_entry;

    // classified item travelling from front to back
    typedef struct packed {
        logic        opcode;
        logic [7:0]  idx;
        t_entry      entry;
        logic [7:0]  data;
        logic        msg_end;
        logic        hex_ok;
        logic [3:0]  hex_val;
        logic        dig_ok;
        logic [3:0]  dig_val;
    } t_item;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
        return r;
    endfunction

endpackage

[sv/imfs_ram.sv]
module imfs_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/imfs_front.sv]
module imfs_front #(
    parameter int MAX_PREFIX_DIGITS = 4,
    parameter int MAX_FIELD_BYTES   = 9999
) (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [7:0]           i_entry_index,
    input  logic [1:0]           i_entry_format,
    input  logic [2:0]           i_entry_prefix_digits,
    input  logic [13:0]          i_entry_max_length,
    input  logic [7:0]           i_message_byte,
    input  logic                 i_message_end,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output imfs_pkg::t_item      o_q_item
);
    import imfs_pkg::*;

    logic [4:0] hex;

    // classify the item: saturate entry fields, decode the byte as hex and digit
    always_comb begin
        hex = hex_decode(i_message_byte);
        o_q_item.opcode = i_opcode;
        o_q_item.idx    = i_entry_index;
        o_q_item.entry.fmt = i_entry_format;
        o_q_item.entry.digits = (32'(i_entry_prefix_digits) > MAX_PREFIX_DIGITS) ?
                                3'(MAX_PREFIX_DIGITS) : i_entry_prefix_digits;
        o_q_item.entry.max_len = (32'(i_entry_max_length) > MAX_FIELD_BYTES) ?
                                 14'(MAX_FIELD_BYTES) : i_entry_max_length;
        o_q_item.data    = i_message_byte;
        o_q_item.msg_end = i_message_end;
        o_q_item.hex_ok  = !hex[4];
        o_q_item.hex_val = hex[3:0];
        o_q_item.dig_ok  = (i_message_byte >= 8'h30) && (i_message_byte <= 8'h39);
        o_q_item.dig_val = 4'(i_message_byte - 8'h30);
    end

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;
endmodule

[sv/imfs_fifo.sv]
module imfs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  imfs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output imfs_pkg::t_item o_item
);
    import imfs_pkg::*;

    t_item      r_slot [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // two-slot queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];
endmodule

[sv/imfs_back.sv]
module imfs_back #(
    parameter int FIELD_COUNT = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_type_len,
    input  logic            i_bitmap_hex,
    input  logic            i_q_valid,
    input  imfs_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_field_number,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_byte_role,
    output logic            o_field_last,
    output logic            o_message_last,
    output logic [2:0]      o_error_code
);
    import imfs_pkg::*;

    // message state
    t_phase            r_phase, n_phase;
    logic [13:0]       r_cnt, n_cnt;
    logic [BITMAP_BITS-1:0] r_bm, n_bm;
    logic              r_ext, n_ext;
    logic [7:0]        r_cur, n_cur;
    logic [13:0]       r_acc, n_acc;
    logic [2:0]        r_err, n_err;
    logic              r_load, n_load;

    // per-entry summary flags for the next-field search
    logic              r_f3  [0:TABLE_DEPTH-1];
    logic              r_fd  [0:TABLE_DEPTH-1];
    logic              r_fm  [0:TABLE_DEPTH-1];

    // output register
    logic              r_ov;
    logic [7:0]        r_fnum, r_byte;
    logic [1:0]        r_role;
    logic              r_last, r_mlast;
    logic [2:0]        r_oerr;

    // entry read with write bypass
    logic [18:0]       ram_rd;
    logic              r_byp_v;
    t_entry            r_byp_d;
    t_entry            ent;

    logic              take, tbl_we, msg;
    logic [7:0]        fnum;
    logic [1:0]        role;
    logic              last;
    logic [2:0]        err;
    logic [7:0]        after;
    int                limit;
    logic              found;
    logic [7:0]        nf;
    logic [BITMAP_BITS-1:0] cand;
    logic [14:0]       cnt_inc;
    logic [4:0]        c;
    logic [16:0]       acc_full;
    logic [13:0]       acc_new, ce;
    logic [6:0]        bidx;
    logic              do_open;

    assign take   = i_q_valid && (i_q_item.opcode == OP_TABLE_WRITE || !r_ov || i_ready);
    assign o_q_pop = take;
    assign tbl_we = take && i_q_item.opcode == OP_TABLE_WRITE &&
                    i_q_item.idx <= 8'(TABLE_DEPTH - 1);
    assign msg    = take && i_q_item.opcode == OP_MSG_BYTE;
    assign ent    = r_byp_v ? r_byp_d : t_entry'(ram_rd);

    imfs_ram #(.WIDTH(19), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_q_item.idx),
        .i_wdata (i_q_item.entry),
        .i_raddr (n_cur),
        .o_rdata (ram_rd)
    );

    // parser: one message byte per cycle while the output register is free or being taken
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_bm = r_bm; n_ext = r_ext;
        n_cur = r_cur; n_acc = r_acc; n_err = r_err; n_load = r_load;
        fnum = 8'd0; role = ROLE_CONTENT; last = 1'b0; err = ERR_NONE;
        do_open = 1'b0; after = r_cur;
        cnt_inc = 15'(r_cnt) + 15'd1;
        c = r_cnt[4:0];
        acc_full = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + 17'(i_q_item.dig_val);
        acc_new = acc_full[13:0];
        ce = r_load ? ent.max_len : r_cnt;
        bidx = 7'd0;
        case (r_phase)
            PH_TYPE: begin
                fnum = 8'd0; role = ROLE_TYPE;
                n_cnt = cnt_inc[13:0];
                if (cnt_inc >= 15'(i_type_len)) begin
                    last = 1'b1; n_phase = PH_BITMAP; n_cnt = 14'd0;
                end
            end
            PH_BITMAP: begin
                fnum = 8'd1; role = ROLE_BITMAP; after = 8'd1;
                if (i_bitmap_hex) begin
                    if (!i_q_item.hex_ok) begin
                        err = ERR_BAD_CHAR;
                    end else begin
                        if (c == 5'd0) n_ext = i_q_item.hex_val[3];
                        for (int j = 0; j < 4; j++) begin
                            bidx = 7'({c, 2'b00}) + 7'(j);
                            if (i_q_item.hex_val[3-j]) n_bm[bidx] = 1'b1;
                        end
                        n_cnt = 14'(c) + 14'd1;
                        if (n_cnt >= (n_ext ? 14'd32 : 14'd16)) begin
                            last = 1'b1; do_open = 1'b1;
                        end
                    end
                end else begin
                    if (c == 5'd0) n_ext = i_q_item.data[7];
                    for (int j = 0; j < 8; j++) begin
                        bidx = 7'({c[3:0], 3'b000}) + 7'(j);
                        if (i_q_item.data[7-j]) n_bm[bidx] = 1'b1;
                    end
                    n_cnt = 14'(c) + 14'd1;
                    if (n_cnt >= (n_ext ? 14'd16 : 14'd8)) begin
                        last = 1'b1; do_open = 1'b1;
                    end
                end
            end
            PH_PREFIX: begin
                fnum = r_cur;
                role = (ent.fmt == FMT_BINARY) ? ROLE_CONTENT : ROLE_PREFIX;
                if (!i_q_item.dig_ok) begin
                    err = ERR_BAD_CHAR;
                end else begin
                    n_acc = acc_new;
                    n_cnt = cnt_inc[13:0];
                    if (cnt_inc >= 15'(ent.digits)) begin
                        if (acc_new > ent.max_len) begin
                            err = ERR_TOO_LONG;
                        end else if (acc_new == 14'd0) begin
                            last = 1'b1; do_open = 1'b1;
                        end else begin
                            n_phase = PH_CONTENT; n_cnt = acc_new; n_load = 1'b0;
                        end
                    end
                end
            end
            PH_CONTENT: begin
                fnum = r_cur; role = ROLE_CONTENT;
                if (ce != 14'd0) ce = ce - 14'd1;
                n_cnt = ce; n_load = 1'b0;
                if (ce == 14'd0) begin
                    last = 1'b1; do_open = 1'b1;
                end
            end
            default: begin
                fnum = 8'd0; role = ROLE_CONTENT;
            end
        endcase

        // next present field with something to parse
        limit = n_ext ? 128 : 64;
        if (limit > FIELD_COUNT) limit = FIELD_COUNT;
        for (int k = 0; k < BITMAP_BITS; k++) begin
            cand[k] = n_bm[k] && (k >= int'(after)) && (k < limit) &&
                      (r_f3[k+1] || r_fd[k+1] || r_fm[k+1]);
        end
        found = 1'b0; nf = 8'd0;
        for (int k = BITMAP_BITS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                found = 1'b1; nf = 8'(k + 1);
            end
        end
        if (do_open) begin
            if (!found) begin
                n_phase = PH_DONE;
            end else if (r_f3[nf]) begin
                n_cur = nf; err = ERR_BAD_FMT;
            end else if (r_fd[nf]) begin
                n_cur = nf; n_phase = PH_PREFIX; n_cnt = 14'd0; n_acc = 14'd0;
            end else begin
                n_cur = nf; n_phase = PH_CONTENT; n_load = 1'b1;
            end
        end

        // error latch and early end
        if (err != ERR_NONE) begin
            last = 1'b0;
            if (r_err == ERR_NONE) n_err = err;
            n_phase = PH_ERROR;
        end
        if (i_q_item.msg_end && n_err == ERR_NONE && n_phase != PH_DONE) begin
            n_err = ERR_EARLY; n_phase = PH_ERROR;
        end

        if (!msg) begin
            n_phase = r_phase; n_cnt = r_cnt; n_bm = r_bm; n_ext = r_ext;
            n_cur = r_cur; n_acc = r_acc; n_err = r_err; n_load = r_load;
        end

        // fixed length is taken when the field opens; keep it if the entry is rewritten
        if (tbl_we && r_load && i_q_item.idx == r_cur) begin
            n_cnt = ent.max_len; n_load = 1'b0;
        end
    end

    // message state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE; r_cnt <= '0; r_bm <= '0; r_ext <= 1'b0;
            r_cur <= '0; r_acc <= '0; r_err <= ERR_NONE; r_load <= 1'b0;
        end else if (msg && i_q_item.msg_end) begin
            r_phase <= PH_TYPE; r_cnt <= '0; r_bm <= '0; r_ext <= 1'b0;
            r_cur <= '0; r_acc <= '0; r_err <= ERR_NONE; r_load <= 1'b0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_bm <= n_bm; r_ext <= n_ext;
            r_cur <= n_cur; r_acc <= n_acc; r_err <= n_err; r_load <= n_load;
        end
    end

    // entry flags and read bypass
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_f3[i_q_item.idx] <= (i_q_item.entry.fmt == FMT_UNDEFINED);
            r_fd[i_q_item.idx] <= (i_q_item.entry.digits != 3'd0);
            r_fm[i_q_item.idx] <= (i_q_item.entry.max_len != 14'd0);
        end
        r_byp_d <= i_q_item.entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_v <= 1'b0;
        end else begin
            r_byp_v <= tbl_we && (i_q_item.idx == n_cur);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (msg) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (msg) begin
            r_fnum  <= fnum;
            r_byte  <= i_q_item.data;
            r_role  <= role;
            r_last  <= last;
            r_mlast <= i_q_item.msg_end;
            r_oerr  <= n_err;
        end
    end

    assign o_valid        = r_ov;
    assign o_field_number = r_fnum;
    assign o_out_byte     = r_byte;
    assign o_byte_role    = r_role;
    assign o_field_last   = r_last;
    assign o_message_last = r_mlast;
    assign o_error_code   = r_oerr;
endmodule

[sv/iso8583_message_field_splitter.sv]
// A message byte is held in the queue, then passes the parser into the output
// register; table writes give no result. The block takes one item per cycle while
// the output is not stalled; the next-field search and length digit accumulation
// are combinational logic in the parser stage.
// Reset: synchronous active-low; clears the parse state, queue and output valid.
// The definition table holds no reset value and must be written before use.
module iso8583_message_field_splitter #(
    parameter int FIELD_COUNT       = 128,
    parameter int MAX_PREFIX_DIGITS = 4,
    parameter int MAX_FIELD_BYTES   = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_entry_index,
    input  logic [1:0]  i_entry_format,
    input  logic [2:0]  i_entry_prefix_digits,
    input  logic [13:0] i_entry_max_length,
    input  logic [7:0]  i_message_byte,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_field_number,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_byte_role,
    output logic        o_field_last,
    output logic        o_message_last,
    output logic [2:0]  o_error_code
);
    import imfs_pkg::*;
    `include "iso8583_message_field_splitter_assert.svh"

    logic [4:0] r_type_len;
    logic       r_bitmap_hex;
    logic [4:0] type_len;
    logic       q_full, q_push, q_pop, q_valid;
    t_item      q_in, q_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_len   <= 5'd4;
            r_bitmap_hex <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TYPE_LEN)   r_type_len   <= i_cfg_data;
            if (i_cfg_index == CFG_BITMAP_HEX) r_bitmap_hex <= i_cfg_data[0];
        end
    end
    assign o_cfg_ready = 1'b1;

    // type code length clamped to 1..16
    assign type_len = (r_type_len == 5'd0) ? 5'd1 :
                      (r_type_len > 5'd16) ? 5'd16 : r_type_len;

    imfs_front #(
        .MAX_PREFIX_DIGITS (MAX_PREFIX_DIGITS),
        .MAX_FIELD_BYTES   (MAX_FIELD_BYTES)
    ) u_front (
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_opcode              (i_opcode),
        .i_entry_index         (i_entry_index),
        .i_entry_format        (i_entry_format),
        .i_entry_prefix_digits (i_entry_prefix_digits),
        .i_entry_max_length    (i_entry_max_length),
        .i_message_byte        (i_message_byte),
        .i_message_end         (i_message_end),
        .i_q_full              (q_full),
        .o_q_push              (q_push),
        .o_q_item              (q_in)
    );

    imfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    imfs_back #(.FIELD_COUNT(FIELD_COUNT)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_type_len     (type_len),
        .i_bitmap_hex   (r_bitmap_hex),
        .i_q_valid      (q_valid),
        .i_q_item       (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_number (o_field_number),
        .o_out_byte     (o_out_byte),
        .o_byte_role    (o_byte_role),
        .o_field_last   (o_field_last),
        .o_message_last (o_message_last),
        .o_error_code   (o_error_code)
    );

    // checks; an early end may still close a field on its last byte
    `IMFS_ASSERT_NOW(a_err_no_last, i_clk, i_rst_n, o_valid && o_error_code != ERR_NONE && o_error_code != ERR_EARLY, !o_field_last)
    `IMFS_ASSERT_NOW(a_type_field0, i_clk, i_rst_n, o_valid && o_byte_role == ROLE_TYPE, o_field_number == 8'd0)
    `IMFS_ASSERT_NOW(a_bitmap_field1, i_clk, i_rst_n, o_valid && o_byte_role == ROLE_BITMAP, o_field_number == 8'd1)
    `IMFS_ASSERT_NEXT(a_pop_needs_item, i_clk, i_rst_n, !q_valid, !q_pop || q_valid)
endmodule

[test/iso8583_message_field_splitter_tb.sv]
module iso8583_message_field_splitter_tb;
    import imfs_pkg::*;

    typedef struct {
        bit         op;
        bit [7:0]   idx;
        bit [1:0]   fmt;
        bit [2:0]   dig;
        bit [13:0]  maxl;
        bit [7:0]   data;
        bit         endm;
    } stim_t;

    typedef struct {
        bit [7:0]   fnum;
        bit [7:0]   data;
        bit [1:0]   role;
        bit         flast;
        bit         mlast;
        bit [2:0]   err;
    } tag_t;

    // Tracks the parse of the byte stream and holds the tags still awaited
    class field_tracker;
        bit [1:0]     fmt[129];
        bit [2:0]     dig[129];
        bit [13:0]    maxl[129];
        int           tcl_reg;
        bit           hex_reg;
        t_phase       phase;
        int           cnt;
        logic [127:0] bm;
        bit           ext;
        int           cur;
        int           acc;
        bit [2:0]     err_latch;
        tag_t         expected_tags[$];
        int           errors;

        function new();
            tcl_reg = 4;
            hex_reg = 0;
            errors  = 0;
            clear_message();
        endfunction

        function void clear_message();
            phase     = PH_TYPE;
            cnt       = 0;
            bm        = '0;
            ext       = 0;
            cur       = 0;
            acc       = 0;
            err_latch = ERR_NONE;
        endfunction

        function void write_reg(bit [1:0] idx, bit [4:0] v);
            if (idx == CFG_TYPE_LEN) tcl_reg = v;
            else if (idx == CFG_BITMAP_HEX) hex_reg = v[0];
        endfunction

        function int eff_dig(int n);
            return (dig[n] > 4) ? 4 : dig[n];
        endfunction

        function int eff_max(int n);
            return (maxl[n] > 9999) ? 9999 : maxl[n];
        endfunction

        function int hex_val(bit [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "A" && c <= "F") return c - "A" + 10;
            if (c >= "a" && c <= "f") return c - "a" + 10;
            return 16;
        endfunction

        // open the next present field after 'after'
        function bit [2:0] open_next(int after);
            int lim;
            int n;
            lim = ext ? 128 : 64;
            for (n = ((after < 1) ? 1 : after) + 1; n <= lim; n++) begin
                if (!bm[128-n]) continue;
                if (fmt[n] == FMT_UNDEFINED) begin
                    cur = n;
                    return ERR_BAD_FMT;
                end
                if (eff_dig(n) > 0) begin
                    cur = n; phase = PH_PREFIX; cnt = 0; acc = 0;
                    return ERR_NONE;
                end
                if (eff_max(n) > 0) begin
                    cur = n; phase = PH_CONTENT; cnt = eff_max(n);
                    return ERR_NONE;
                end
            end
            phase = PH_DONE;
            return ERR_NONE;
        endfunction

        function void note_input(stim_t s);
            tag_t t;
            int tcl, c, v, len;
            bit [2:0] e;
            if (s.op == OP_TABLE_WRITE) begin
                if (s.idx <= 128) begin
                    fmt[s.idx]  = s.fmt;
                    dig[s.idx]  = s.dig;
                    maxl[s.idx] = s.maxl;
                end
                return;
            end
            t.fnum = 0; t.role = ROLE_CONTENT; t.flast = 0; e = ERR_NONE;
            case (phase)
                PH_TYPE: begin
                    tcl = (tcl_reg < 1) ? 1 : (tcl_reg > 16) ? 16 : tcl_reg;
                    t.role = ROLE_TYPE;
                    cnt++;
                    if (cnt >= tcl) begin
                        t.flast = 1; phase = PH_BITMAP; cnt = 0;
                    end
                end
                PH_BITMAP: begin
                    c = cnt & 31;
                    t.fnum = 1; t.role = ROLE_BITMAP;
                    if (hex_reg) begin
                        v = hex_val(s.data);
                        if (v > 15) e = ERR_BAD_CHAR;
                        else begin
                            if (c == 0) ext = v[3];
                            bm[127-4*(c&15)-64*((c>>4)&1) -: 4] = v[3:0];
                            len = ext ? 32 : 16;
                        end
                    end else begin
                        if (c == 0) ext = s.data[7];
                        bm[127-8*(c&7)-64*((c>>3)&1) -: 8] = s.data;
                        len = ext ? 16 : 8;
                    end
                    if (e == ERR_NONE) begin
                        cnt = c + 1;
                        if (cnt >= len) begin
                            t.flast = 1;
                            e = open_next(1);
                        end
                    end
                end
                PH_PREFIX: begin
                    t.fnum = cur;
                    t.role = (fmt[cur] == FMT_BINARY) ? ROLE_CONTENT : ROLE_PREFIX;
                    if (s.data < "0" || s.data > "9") e = ERR_BAD_CHAR;
                    else begin
                        acc = (acc * 10 + (s.data - "0")) & 16'h3FFF;
                        cnt++;
                        if (cnt >= eff_dig(cur)) begin
                            if (acc > eff_max(cur)) e = ERR_TOO_LONG;
                            else if (acc == 0) begin
                                t.flast = 1;
                                e = open_next(cur);
                            end else begin
                                phase = PH_CONTENT; cnt = acc;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    t.fnum = cur;
                    if (cnt > 0) cnt--;
                    if (cnt == 0) begin
                        t.flast = 1;
                        e = open_next(cur);
                    end
                end
                default: ;
            endcase
            if (e != ERR_NONE) begin
                t.flast = 0;
                if (err_latch == ERR_NONE) err_latch = e;
                phase = PH_ERROR;
            end
            if (s.endm && err_latch == ERR_NONE && phase != PH_DONE) begin
                err_latch = ERR_EARLY;
                phase = PH_ERROR;
            end
            t.data  = s.data;
            t.mlast = s.endm;
            t.err   = err_latch;
            expected_tags.push_back(t);
            if (s.endm) clear_message();
        endfunction

        function void check_tag(tag_t a);
            tag_t e;
            if (expected_tags.size() == 0) begin
                $error("output item with nothing expected");
                errors++;
                return;
            end
            e = expected_tags.pop_front();
            if (a.fnum != e.fnum) begin
                $error("field_number expected %0d got %0d", e.fnum, a.fnum); errors++;
            end
            if (a.data != e.data) begin
                $error("out_byte expected %0h got %0h", e.data, a.data); errors++;
            end
            if (a.role != e.role) begin
                $error("byte_role expected %0d got %0d", e.role, a.role); errors++;
            end
            if (a.flast != e.flast) begin
                $error("field_last expected %0d got %0d", e.flast, a.flast); errors++;
            end
            if (a.mlast != e.mlast) begin
                $error("message_last expected %0d got %0d", e.mlast, a.mlast); errors++;
            end
            if (a.err != e.err) begin
                $error("error_code expected %0d got %0d", e.err, a.err); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [7:0]  i_entry_index;
    logic [1:0]  i_entry_format;
    logic [2:0]  i_entry_prefix_digits;
    logic [13:0] i_entry_max_length;
    logic [7:0]  i_message_byte;
    logic        i_message_end;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_field_number;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_byte_role;
    logic        o_field_last;
    logic        o_message_last;
    logic [2:0]  o_error_code;

    field_tracker sb = new();
    bit  idle_on  = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  stall = 0;
    int  cycles = 0;
    int  msg_items = 0;

    iso8583_message_field_splitter i_dut (.*);

    // clock
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure: per-item stall plus one long hold-off
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_ready = 0;
                hold_left--;
            end else if (stall > 0) begin
                i_ready = 0;
                stall--;
            end else begin
                i_ready = 1;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        tag_t a;
        if (i_rst_n && o_valid && i_ready) begin
            a.fnum = o_field_number; a.data = o_out_byte; a.role = o_byte_role;
            a.flast = o_field_last; a.mlast = o_message_last; a.err = o_error_code;
            sb.check_tag(a);
            stall = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    // offer one item; called and returns at a falling edge
    task automatic send(stim_t s);
        int gap;
        i_valid = 1;
        i_opcode = s.op; i_entry_index = s.idx; i_entry_format = s.fmt;
        i_entry_prefix_digits = s.dig; i_entry_max_length = s.maxl;
        i_message_byte = s.data; i_message_end = s.endm;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(s);
        if (s.op == OP_MSG_BYTE) msg_items++;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_entry(int idx, bit [1:0] f, bit [2:0] d, bit [13:0] m);
        stim_t s;
        s.op = OP_TABLE_WRITE; s.idx = idx; s.fmt = f; s.dig = d; s.maxl = m;
        s.data = $urandom; s.endm = $urandom;
        send(s);
    endtask

    // wait for every awaited item, then let the pipeline settle
    task automatic drain();
        i_valid = 0;
        while (sb.expected_tags.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(bit [1:0] idx, bit [4:0] v);
        i_cfg_valid = 1; i_cfg_index = idx; i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // build and send one message; mode 0 good, 1 cut short, 2 bad character,
    // 3 length over maximum, 4 trailing bytes
    task automatic run_message(logic [127:0] bm, int mode);
        bit [7:0] q[$];
        int chk[$];
        int tcl, n, k, d, mx, cap, len, nb, lim;
        bit over;
        bit [3:0] nib;
        bit [7:0] bad[6];
        stim_t s;
        bad = '{"/", ":", "G", "g", 8'hFF, 8'h00};
        over = 0;
        tcl = (sb.tcl_reg < 1) ? 1 : (sb.tcl_reg > 16) ? 16 : sb.tcl_reg;
        repeat (tcl) q.push_back($urandom);
        if (sb.hex_reg) begin
            for (k = 0; k < (bm[127] ? 32 : 16); k++) begin
                nib = bm[127-4*k -: 4];
                chk.push_back(q.size());
                if (nib < 10) q.push_back("0" + nib);
                else q.push_back((($urandom & 1) ? "A" : "a") + nib - 10);
            end
        end else begin
            for (k = 0; k < (bm[127] ? 16 : 8); k++) q.push_back(bm[127-8*k -: 8]);
        end
        lim = bm[127] ? 128 : 64;
        for (n = 2; n <= lim; n++) begin
            if (!bm[128-n]) continue;
            if (sb.fmt[n] == FMT_UNDEFINED) break;
            d  = sb.eff_dig(n);
            mx = sb.eff_max(n);
            if (d > 0) begin
                cap = (10 ** d) - 1;
                if (cap > mx) cap = mx;
                if (mode == 3 && mx < (10 ** d) - 1) begin
                    len = mx + 1;
                    over = 1;
                end else if ($urandom_range(0, 7) == 0) len = 0;
                else if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(0, (cap < 200) ? cap : 200);
                else len = $urandom_range(0, (cap < 12) ? cap : 12);
                for (k = d - 1; k >= 0; k--) begin
                    chk.push_back(q.size());
                    q.push_back("0" + (len / (10 ** k)) % 10);
                end
                if (over) begin
                    repeat (3) q.push_back($urandom);
                    break;
                end
                repeat (len) q.push_back($urandom);
            end else begin
                repeat (mx) q.push_back($urandom);
            end
        end
        case (mode)
            1: if (q.size() > 1) begin
                nb = $urandom_range(1, q.size() - 1);
                while (q.size() > nb) void'(q.pop_back());
            end
            2: if (chk.size() > 0) q[chk[$urandom_range(0, chk.size() - 1)]] = bad[$urandom_range(0, 5)];
            4: repeat ($urandom_range(1, 5)) q.push_back($urandom);
            default: ;
        endcase
        foreach (q[i]) begin
            s.op = OP_MSG_BYTE; s.idx = $urandom; s.fmt = $urandom; s.dig = $urandom;
            s.maxl = $urandom; s.data = q[i]; s.endm = (i == q.size() - 1);
            send(s);
        end
    endtask

    function automatic logic [127:0] pick_bitmap();
        logic [127:0] bm;
        bm = '0;
        bm[127] = $urandom_range(0, 3) == 0;
        for (int n = 2; n <= (bm[127] ? 128 : 64); n++)
            bm[128-n] = $urandom_range(0, bm[127] ? 19 : 11) == 0;
        bm[63:0] = bm[127] ? bm[63:0] : 64'($urandom) << 32 | 64'($urandom);
        return bm;
    endfunction

    task automatic random_entry();
        int r;
        bit [13:0] m;
        r = $urandom_range(0, 19);
        m = (r == 0) ? $urandom_range(0, 16383) : (r < 3) ? 0 : $urandom_range(1, 40);
        if ($urandom_range(0, 3) == 0) begin
            if (m > 300) m = $urandom_range(0, 300);
            write_entry($urandom_range(2, 128), $urandom_range(0, 2), 0, m);
        end else begin
            write_entry($urandom_range(2, 128),
                        ($urandom_range(0, 20) == 0) ? FMT_UNDEFINED : $urandom_range(0, 2),
                        $urandom_range(1, 7), m);
        end
    endtask

    function automatic logic [127:0] fields(int a, int b, int c, bit x);
        logic [127:0] bm;
        bm = '0;
        bm[127] = x;
        if (a > 1) bm[128-a] = 1;
        if (b > 1) bm[128-b] = 1;
        if (c > 1) bm[128-c] = 1;
        return bm;
    endfunction

    // main sequence
    initial begin
        logic [127:0] bm;
        int r, ph;
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_valid = 0; i_opcode = 0; i_entry_index = 0; i_entry_format = 0;
        i_entry_prefix_digits = 0; i_entry_max_length = 0;
        i_message_byte = 0; i_message_end = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        cfg_write(CFG_TYPE_LEN, 4);
        cfg_write(CFG_BITMAP_HEX, 0);
        // fill the whole definition table before any message
        for (int n = 0; n <= 128; n++)
            write_entry(n, $urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 12));
        write_entry(200, FMT_UNDEFINED, 7, 14'h3FFF);
        write_entry(255, FMT_UNDEFINED, 7, 14'h3FFF);
        write_entry(2, 0, 2, 10);
        write_entry(3, 1, 0, 6);
        write_entry(4, FMT_BINARY, 3, 20);
        write_entry(5, FMT_UNDEFINED, 2, 5);
        write_entry(6, 1, 0, 0);
        write_entry(7, 0, 7, 14'h3FFF);
        write_entry(128, FMT_BINARY, 0, 2);

        // directed messages
        bm = fields(2, 3, 4, 0); bm[128-6] = 1; bm[128-7] = 1;
        run_message(bm, 0);
        run_message(fields(2, 128, 0, 1), 0);
        run_message(fields(2, 0, 0, 0), 3);
        run_message(fields(5, 0, 0, 0), 0);
        run_message(fields(3, 0, 0, 0), 1);
        run_message(fields(3, 0, 0, 0), 4);
        drain();
        cfg_write(CFG_BITMAP_HEX, 1);
        cfg_write(CFG_TYPE_LEN, 1);
        run_message(fields(3, 128, 0, 1), 0);
        run_message(fields(2, 0, 0, 0), 2);
        drain();
        cfg_write(CFG_TYPE_LEN, 16);
        run_message(fields(4, 0, 0, 0), 0);
        drain();
        cfg_write(CFG_TYPE_LEN, 0);
        run_message(fields(0, 0, 0, 0), 0);
        drain();
        cfg_write(CFG_TYPE_LEN, 31);
        cfg_write(CFG_BITMAP_HEX, 0);
        run_message(fields(6, 0, 0, 0), 0);
        drain();

        // random phases
        ph = 0;
        while (msg_items < 1250) begin
            drain();
            r = $urandom_range(0, 5);
            cfg_write(CFG_TYPE_LEN, (r == 0) ? 1 : (r == 1) ? 16 : (r == 2) ? $urandom_range(0, 31)
                                      : $urandom_range(1, 16));
            cfg_write(CFG_BITMAP_HEX, $urandom_range(0, 1));
            idle_on = $urandom_range(0, 3) != 0;
            if (ph == 1) hold_req = 1;
            repeat ($urandom_range(2, 8)) random_entry();
            repeat (6) begin
                if ($urandom_range(0, 9) == 0) random_entry();
                if ($urandom_range(0, 19) == 0)
                    write_entry($urandom_range(129, 255), $urandom, $urandom, $urandom);
                r = $urandom_range(0, 9);
                run_message(pick_bitmap(), (r < 6) ? 0 : r - 5);
            end
            ph++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
